@@ rtl/core/counter_priority_task_scheduler_defines.svh @@
// Assertion macros used by the scheduler RTL.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CPTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// next-cycle implication
`define CPTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define CPTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/cpts_pkg.sv @@
// Types and constants of the counter priority task scheduler.
`timescale 1ns / 1ps
package cpts_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int MS_PER_S      = 1000;
    localparam int SLP_W         = 26;

    localparam logic [9:0] TICK_MS_RST = 10'd10;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_SLEEPING = 2'd1;
    localparam logic [1:0] ST_EXITED   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SLEEP = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic        present;
        logic [1:0]  status;
        logic [7:0]  counter;
        logic [5:0]  prio;
        logic [31:0] wakeup;
    } t_entry;

    localparam t_entry ENTRY_RST = '{
        present: 1'b0,
        status:  ST_RUNNING,
        counter: 8'd0,
        prio:    6'd1,
        wakeup:  32'd0
    };

    typedef struct packed {
        t_entry wb;
        logic   hit;
    } t_scan_res;

    // lowest bit up: chosen, switched, none, recharged
    typedef struct packed {
        logic       rech;
        logic       none;
        logic       sw;
        logic [2:0] chosen;
    } t_result;

endpackage

@@ rtl/core/cpts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/core/cpts_scan_unit.sv @@
// Per-slot scan step: wake-up or recharge of one entry and best-counter compare.
`timescale 1ns / 1ps
module cpts_scan_unit
    import cpts_pkg::*;
(
    input  t_entry      i_entry,
    input  logic        i_pass,
    input  logic [31:0] i_now,
    input  logic        i_found,
    input  logic [7:0]  i_bcnt,
    output t_scan_res   o_res
);

    t_entry wb;

    always_comb begin
        wb = i_entry;
        if (!i_pass) begin
            if (i_entry.present && (i_entry.status != ST_EXITED) &&
                (i_now > i_entry.wakeup)) begin
                wb.status = ST_RUNNING;
            end
        end else if (i_entry.present) begin
            wb.counter = 8'(i_entry.prio) + {1'b0, i_entry.counter[7:1]};
        end
    end

    assign o_res.wb  = wb;
    assign o_res.hit = wb.present && (wb.status == ST_RUNNING) &&
                       (!i_found || (wb.counter > i_bcnt));

endmodule

@@ rtl/core/counter_priority_task_scheduler.sv @@
// Top level of the counter priority task scheduler.
`timescale 1ns / 1ps
// Task slots live in one RAM, read one entry per cycle through its single
// registered read port. A load or a tick that only decrements reads and
// writes the current slot only; a tick that empties the slice or a sleep
// also walks every slot, and walks them twice when all counters recharge.
// No clearing pass after reset: per-slot valid bits make unwritten slots
// read as their reset value. A result held at the output does not stop the
// next beat from being accepted.
`include "counter_priority_task_scheduler_defines.svh"
module counter_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,     // tick_ms
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // slot_index[2:0], slot_present[3], slot_status[5:4], slot_priority[11:6],
    // slot_counter[19:12], sleep_seconds[35:20], zero[39:36]
    input  logic [39:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,  // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // chosen_slot[2:0], switched[3], none_runnable[4], recharged[5], zero[7:6]
    output logic [7:0]  o_m_axis_tdata
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = IW + 1;
    localparam int AW = (IW > 3) ? IW : 3;
    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CUR  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [9:0]           r_tick;
    logic [31:0]          r_now, n_now;
    logic [IW-1:0]        r_cur, n_cur;
    logic [NUM_TASKS-1:0] r_vbits;
    logic                 r_pend, n_pend;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pass, n_pass;
    logic                 r_found, n_found;
    logic                 r_rech, n_rech;
    logic                 r_sched, n_sched;
    logic                 r_ovld, n_ovld;
    logic [IW-1:0]        r_raddr, n_raddr;
    t_op                  r_op, n_op;
    logic [SLP_W-1:0]     r_slp_ms, n_slp_ms;
    t_entry               r_ld, n_ld;
    logic [7:0]           r_bcnt, n_bcnt;
    logic [IW-1:0]        r_best, n_best;
    logic                 r_p0, n_p0;
    t_result              r_out, n_out;

    logic          s_acc, emit, ld_in_range, sw;
    t_op           in_op;
    logic [AW-1:0] ld_ext, ch_ext;
    logic [IW-1:0] ch_idx;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    t_entry        wr_data, e_rd;
    logic [EW-1:0] ram_q;
    t_scan_res     sr;

    assign in_op       = t_op'(i_s_axis_tuser);
    assign s_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign ld_ext      = AW'(i_s_axis_tdata[2:0]);
    assign ld_in_range = 32'(i_s_axis_tdata[2:0]) < 32'(NUM_TASKS);
    assign emit        = (r_state == S_DONE) && (!r_ovld || i_m_axis_tready);
    assign sw          = r_found || r_p0;
    assign ch_idx      = r_sched ? (r_found ? r_best : '0) : r_cur;
    assign ch_ext      = AW'(ch_idx);
    assign e_rd        = r_vbits[r_raddr] ? t_entry'(ram_q) : ENTRY_RST;

    cpts_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    cpts_scan_unit u_scan (
        .i_entry (e_rd),
        .i_pass  (r_pass),
        .i_now   (r_now),
        .i_found (r_found),
        .i_bcnt  (r_bcnt),
        .o_res   (sr)
    );

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_cur    = r_cur;
        n_pend   = r_pend;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_found  = r_found;
        n_rech   = r_rech;
        n_sched  = r_sched;
        n_ovld   = r_ovld && !i_m_axis_tready;
        n_raddr  = r_raddr;
        n_op     = r_op;
        n_slp_ms = r_slp_ms;
        n_ld     = r_ld;
        n_bcnt   = r_bcnt;
        n_best   = r_best;
        n_p0     = r_p0;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_raddr;
        wr_data  = e_rd;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op         = in_op;
                    n_sched      = 1'b0;
                    n_ld.present = i_s_axis_tdata[3];
                    n_ld.status  = i_s_axis_tdata[5:4];
                    n_ld.prio    = (i_s_axis_tdata[11:6] == 6'd0) ? 6'd1
                                                                  : i_s_axis_tdata[11:6];
                    n_ld.counter = i_s_axis_tdata[19:12];
                    n_ld.wakeup  = '0;
                    n_slp_ms     = SLP_W'(i_s_axis_tdata[35:20]) * SLP_W'(MS_PER_S);
                    case (in_op)
                        OP_TICK, OP_SLEEP: begin
                            if (in_op == OP_TICK) begin
                                n_now = r_now + 32'(r_tick);
                            end
                            rd_en   = 1'b1;
                            rd_addr = r_cur;
                            n_pend  = 1'b1;
                            n_raddr = r_cur;
                            n_state = S_CUR;
                        end
                        OP_LOAD: begin
                            if (ld_in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = ld_ext[IW-1:0];
                                n_pend  = 1'b1;
                                n_raddr = ld_ext[IW-1:0];
                                n_state = S_CUR;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_CUR: begin
                n_pend = 1'b0;
                wr_en  = 1'b1;
                case (r_op)
                    OP_TICK: begin
                        if (e_rd.counter > 8'd1) begin
                            wr_data.counter = e_rd.counter - 8'd1;
                            n_state         = S_DONE;
                        end else begin
                            wr_data.counter = 8'd0;
                            n_sched         = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    OP_SLEEP: begin
                        wr_data.wakeup = r_now + 32'(r_slp_ms);
                        wr_data.status = ST_SLEEPING;
                        n_sched        = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default: begin
                        wr_data        = r_ld;
                        wr_data.wakeup = e_rd.wakeup;
                        n_state        = S_DONE;
                    end
                endcase
                n_idx   = '0;
                n_pass  = 1'b0;
                n_found = 1'b0;
                n_rech  = 1'b0;
            end

            S_SCAN: begin
                if (r_idx < CW'(NUM_TASKS)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[IW-1:0];
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                    n_raddr = r_idx[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_data = sr.wb;
                    if (sr.hit) begin
                        n_found = 1'b1;
                        n_bcnt  = sr.wb.counter;
                        n_best  = r_raddr;
                    end
                    if (!r_pass && (r_raddr == '0)) begin
                        n_p0 = e_rd.present;
                    end
                    if (r_raddr == IW'(NUM_TASKS - 1)) begin
                        if (!r_pass && n_found && (n_bcnt == 8'd0)) begin
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_rech  = 1'b1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            S_DONE: begin
                if (emit) begin
                    n_ovld       = 1'b1;
                    n_out.chosen = ch_ext[2:0];
                    n_out.sw     = r_sched && sw;
                    n_out.none   = r_sched && !r_found;
                    n_out.rech   = r_sched && r_rech;
                    if (r_sched && sw) begin
                        n_cur = ch_idx;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= TICK_MS_RST;
            r_now   <= '0;
            r_cur   <= '0;
            r_vbits <= '0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_pass  <= 1'b0;
            r_found <= 1'b0;
            r_rech  <= 1'b0;
            r_sched <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
            r_now <= n_now;
            r_cur <= n_cur;
            if (wr_en) begin
                r_vbits[wr_addr] <= 1'b1;
            end
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_found <= n_found;
            r_rech  <= n_rech;
            r_sched <= n_sched;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr  <= n_raddr;
        r_op     <= n_op;
        r_slp_ms <= n_slp_ms;
        r_ld     <= n_ld;
        r_bcnt   <= n_bcnt;
        r_best   <= n_best;
        r_p0     <= n_p0;
        r_out    <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {2'b00, r_out};

    `CPTS_ASSERT_IMP(a_idle_no_read, i_clk, i_rst_n, r_state == S_IDLE, !r_pend)
    `CPTS_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, wr_en && rd_en, wr_addr != rd_addr)
    `CPTS_ASSERT_IMP(a_rech_has_pick, i_clk, i_rst_n, r_ovld, !(r_out.none && r_out.rech))
    `CPTS_ASSERT_NXT(a_cur_follows, i_clk, i_rst_n, emit && r_sched && r_found, r_cur == $past(r_best))
    `CPTS_ASSERT_IMP(a_cur_range, i_clk, i_rst_n, 1'b1, 32'(r_cur) < 32'(NUM_TASKS))

endmodule
